### src/nlc_pkg.sv
// ----------------------------------------------------------------------------
// nlc_pkg
// Shared widths and operation codes for the neighbor cache.
// ----------------------------------------------------------------------------
package nlc_pkg;

    localparam int KEY_HALF_W = 64;
    localparam int V4_W       = 32;
    localparam int MAC_W      = 48;
    localparam int TIME_W     = 32;
    localparam int TMO_W      = 17;

    // tdata widths, padded to whole bytes
    localparam int IN_DATA_W  = 208;
    localparam int OUT_DATA_W = 56;
    localparam int IN_USER_W  = 3;

    typedef logic [1:0] func_t;

    localparam func_t FUNC_UPD_MAC   = 2'd0;
    localparam func_t FUNC_UPD_NOMAC = 2'd1;
    localparam func_t FUNC_LOOKUP    = 2'd2;
    localparam func_t FUNC_CLEAR     = 2'd3;

    typedef logic [0:0] cfg_idx_t;

    localparam cfg_idx_t CFG_ENTRY_TMO = 1'd0;
    localparam cfg_idx_t CFG_NOMAC_TMO = 1'd1;

    // Per-entry payload held in the data memory
    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic              mac_known;
        logic [TIME_W-1:0] stamp;
    } slot_data_t;

endpackage

### src/neighbor_lru_cache_with_timeouts.sv
// ----------------------------------------------------------------------------
// neighbor_lru_cache_with_timeouts
// Address-to-MAC cache with LRU eviction and per-entry expiry.
// ----------------------------------------------------------------------------
// Lookups and updates scan every entry; clear skips the scans. One item in
// flight at a time, and any wait on the result port holds it; the next item
// is accepted the cycle after the result is issued.
// Lookups scan the key memory, updates also the recency-rank memory, one
// entry per cycle through a single read port.
// Reset empties the store at once (valid bits in flip-flops) and loads the
// timeouts with 600 s and 60 s; no clearing pass is needed.
module neighbor_lru_cache_with_timeouts
    import nlc_pkg::*;
#(
    parameter int ENTRIES = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // addr_high[63:0], addr_low[127:64], mac_in[175:128], now_seconds[207:176]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // func[1:0], is_ipv6[2]
    input  logic [IN_USER_W-1:0]  s_tuser,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // hit[0], entry_valid[1], has_mac[2], mac_out[50:3], evicted[51], zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_idx_t              cfg_index,
    input  logic [TMO_W-1:0]      cfg_data
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int KW = 2 * KEY_HALF_W + 1;
    localparam logic [AW-1:0] LAST_IDX   = AW'(ENTRIES - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_RKRD   = 3'd3;
    localparam logic [2:0] ST_RANK   = 3'd4;
    localparam logic [2:0] ST_WRITE  = 3'd5;
    localparam logic [2:0] ST_LKRD   = 3'd6;
    localparam logic [2:0] ST_FIN    = 3'd7;

    // Memories
    logic [KW-1:0]  key_mem  [ENTRIES];
    slot_data_t     data_mem [ENTRIES];
    logic [AW-1:0]  rank_mem [ENTRIES];

    logic [KW-1:0]  key_q_reg;
    slot_data_t     data_q_reg;
    logic [AW-1:0]  rank_q_reg;

    // Control state
    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [ENTRIES-1:0]  used_reg;
    logic [CW-1:0]       live_cnt_reg;
    logic [TMO_W-1:0]    entry_tmo_reg;
    logic [TMO_W-1:0]    nomac_tmo_reg;

    // Request
    func_t               req_func_reg;
    logic [KW-1:0]       req_key_reg;
    logic [MAC_W-1:0]    req_mac_reg;
    logic [TIME_W-1:0]   req_now_reg;

    // Scan pipeline
    logic [AW:0]         iss_cnt_reg;
    logic                rd_vld_reg;
    logic [AW-1:0]       rd_idx_reg;
    logic                found_reg;
    logic                free_found_reg;
    logic [AW-1:0]       slot_reg;
    logic [AW-1:0]       free_idx_reg;
    logic [AW-1:0]       hit_rank_reg;

    // Result
    logic                res_hit_reg;
    logic                res_valid_reg;
    logic                res_has_mac_reg;
    logic [MAC_W-1:0]    res_mac_reg;
    logic                res_evicted_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                out_valid_reg;

    logic                in_fire;
    logic                key_match;
    logic                rank_touch;
    logic [AW-1:0]       rank_new;
    logic                evict_req;
    logic                entry_ok;
    logic                is_update;
    logic [AW-1:0]       rank_rd_addr;
    logic                rank_we;
    logic [AW-1:0]       rank_wa;
    logic [AW-1:0]       rank_wd;
    logic                out_load;
    logic [KW-1:0]       in_key;

    assign in_fire   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tdata   = out_data_reg;
    assign m_tvalid  = out_valid_reg;
    assign is_update = (req_func_reg == FUNC_UPD_MAC) || (req_func_reg == FUNC_UPD_NOMAC);
    assign out_load  = (state_reg == ST_FIN) && (!out_valid_reg || m_tready);

    // IPv4 keys keep only the low 32 address bits
    assign in_key = s_tuser[2] ?
                    {1'b1, s_tdata[KEY_HALF_W-1:0], s_tdata[2*KEY_HALF_W-1:KEY_HALF_W]} :
                    {1'b0, {KEY_HALF_W{1'b0}},
                     {(KEY_HALF_W-V4_W){1'b0}}, s_tdata[KEY_HALF_W+V4_W-1:KEY_HALF_W]};

    assign key_match = rd_vld_reg && used_reg[rd_idx_reg] && (key_q_reg == req_key_reg);

    // Rank pass: a hit bumps younger entries, an insert bumps all
    assign rank_touch = rd_vld_reg && used_reg[rd_idx_reg] &&
                        !(found_reg && (rd_idx_reg == slot_reg));
    assign rank_new   = (!found_reg || (rank_q_reg < hit_rank_reg)) ?
                        rank_q_reg + AW'(1) : rank_q_reg;
    assign evict_req  = !found_reg && (live_cnt_reg == FULL_COUNT);

    assign rank_rd_addr = (state_reg == ST_DECIDE) ? slot_reg : iss_cnt_reg[AW-1:0];

    // Single rank write port
    always_comb
    begin
        rank_we = 1'b0;
        rank_wa = rd_idx_reg;
        rank_wd = rank_new;
        if (state_reg == ST_RANK && rank_touch)
        begin
            rank_we = 1'b1;
        end
        else if (state_reg == ST_WRITE)
        begin
            rank_we = 1'b1;
            rank_wa = slot_reg;
            rank_wd = '0;
        end
    end

    // Memory arrays
    always_ff @(posedge clk)
    begin
        key_q_reg  <= key_mem[iss_cnt_reg[AW-1:0]];
        data_q_reg <= data_mem[slot_reg];
        rank_q_reg <= rank_mem[rank_rd_addr];
        if (rank_we)
        begin
            rank_mem[rank_wa] <= rank_wd;
        end
        if (state_reg == ST_WRITE)
        begin
            data_mem[slot_reg] <= '{mac: req_mac_reg,
                                    mac_known: (req_func_reg == FUNC_UPD_MAC),
                                    stamp: req_now_reg};
            if (!found_reg)
            begin
                key_mem[slot_reg] <= req_key_reg;
            end
        end
    end

    nlc_expiry u_expiry (
        .entry         (data_q_reg),
        .now_seconds   (req_now_reg),
        .entry_timeout (entry_tmo_reg),
        .nomac_timeout (nomac_tmo_reg),
        .entry_valid   (entry_ok)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (s_tuser[1:0] == FUNC_CLEAR) ? ST_FIN : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_vld_reg && rd_idx_reg == LAST_IDX)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!is_update)
                begin
                    state_next = found_reg ? ST_LKRD : ST_FIN;
                end
                else
                begin
                    state_next = (found_reg || free_found_reg) ? ST_RKRD : ST_FIN;
                end
            end
            ST_RKRD:
            begin
                state_next = ST_RANK;
            end
            ST_RANK:
            begin
                if (rd_vld_reg && rd_idx_reg == LAST_IDX)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_FIN;
            end
            ST_LKRD:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            used_reg        <= '0;
            live_cnt_reg    <= '0;
            entry_tmo_reg   <= TMO_W'(600);
            nomac_tmo_reg   <= TMO_W'(60);
            req_func_reg    <= FUNC_UPD_MAC;
            req_key_reg     <= '0;
            req_mac_reg     <= '0;
            req_now_reg     <= '0;
            iss_cnt_reg     <= '0;
            rd_vld_reg      <= 1'b0;
            rd_idx_reg      <= '0;
            found_reg       <= 1'b0;
            free_found_reg  <= 1'b0;
            slot_reg        <= '0;
            free_idx_reg    <= '0;
            hit_rank_reg    <= '0;
            out_valid_reg   <= 1'b0;
            res_hit_reg     <= 1'b0;
            res_valid_reg   <= 1'b0;
            res_has_mac_reg <= 1'b0;
            res_mac_reg     <= '0;
            res_evicted_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ENTRY_TMO: entry_tmo_reg <= cfg_data;
                    CFG_NOMAC_TMO: nomac_tmo_reg <= cfg_data;
                    default: ;
                endcase
            end

            // result port
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            // scan issue counter, shared by both passes
            if (state_reg == ST_SCAN || state_reg == ST_RANK)
            begin
                if (iss_cnt_reg < (AW+1)'(ENTRIES))
                begin
                    rd_vld_reg  <= 1'b1;
                    rd_idx_reg  <= iss_cnt_reg[AW-1:0];
                    iss_cnt_reg <= iss_cnt_reg + (AW+1)'(1);
                end
                else
                begin
                    rd_vld_reg <= 1'b0;
                end
            end
            else
            begin
                rd_vld_reg  <= 1'b0;
                iss_cnt_reg <= '0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        req_func_reg    <= s_tuser[1:0];
                        req_key_reg     <= in_key;
                        req_mac_reg     <= s_tdata[2*KEY_HALF_W+MAC_W-1:2*KEY_HALF_W];
                        req_now_reg     <= s_tdata[IN_DATA_W-1:2*KEY_HALF_W+MAC_W];
                        found_reg       <= 1'b0;
                        free_found_reg  <= 1'b0;
                        res_hit_reg     <= 1'b0;
                        res_valid_reg   <= 1'b0;
                        res_has_mac_reg <= 1'b0;
                        res_mac_reg     <= '0;
                        res_evicted_reg <= 1'b0;
                        if (s_tuser[1:0] == FUNC_CLEAR)
                        begin
                            used_reg     <= '0;
                            live_cnt_reg <= '0;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (key_match && !found_reg)
                    begin
                        found_reg <= 1'b1;
                        slot_reg  <= rd_idx_reg;
                    end
                    if (rd_vld_reg && !used_reg[rd_idx_reg] && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= rd_idx_reg;
                    end
                end
                ST_DECIDE:
                begin
                    if (!found_reg)
                    begin
                        slot_reg <= free_idx_reg;
                    end
                end
                ST_RKRD:
                begin
                    hit_rank_reg <= rank_q_reg;
                end
                ST_RANK:
                begin
                    // the oldest entry falls out once the store is full
                    if (rank_touch && evict_req && rank_new == LAST_IDX)
                    begin
                        used_reg[rd_idx_reg] <= 1'b0;
                        live_cnt_reg         <= live_cnt_reg - CW'(1);
                        res_evicted_reg      <= 1'b1;
                    end
                end
                ST_WRITE:
                begin
                    used_reg[slot_reg] <= 1'b1;
                    if (!found_reg)
                    begin
                        live_cnt_reg <= live_cnt_reg + CW'(1);
                    end
                end
                ST_LKRD:
                begin
                    res_hit_reg     <= 1'b1;
                    res_valid_reg   <= entry_ok;
                    res_has_mac_reg <= data_q_reg.mac_known;
                    res_mac_reg     <= data_q_reg.mac_known ? data_q_reg.mac : '0;
                end
                default: ;
            endcase
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {{(OUT_DATA_W-MAC_W-4){1'b0}}, res_evicted_reg, res_mac_reg,
                             res_has_mac_reg, res_valid_reg, res_hit_reg};
        end
    end

    // Checks
    live_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_cnt_reg <= FULL_COUNT)
        else $error("live count above limit");

    live_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (live_cnt_reg == CW'($countones(used_reg))))
        else $error("live count disagrees with valid bits");

    accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != ST_IDLE))
        else $error("item accepted but sequencer stayed idle");

    evict_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RANK && res_evicted_reg) |-> !found_reg)
        else $error("eviction during refresh");

endmodule

### src/nlc_expiry.sv
// ----------------------------------------------------------------------------
// nlc_expiry
// Timeout check of one entry against the current time.
// ----------------------------------------------------------------------------
module nlc_expiry
    import nlc_pkg::*;
(
    input  slot_data_t        entry,
    input  logic [TIME_W-1:0] now_seconds,
    input  logic [TMO_W-1:0]  entry_timeout,
    input  logic [TMO_W-1:0]  nomac_timeout,
    output logic              entry_valid
);

    logic [TIME_W:0] main_limit;
    logic [TIME_W:0] nomac_limit;
    logic [TIME_W:0] now_ext;

    // limits are formed one bit wider so they never wrap
    assign main_limit  = {1'b0, entry.stamp} + (TIME_W+1)'(entry_timeout);
    assign nomac_limit = {1'b0, entry.stamp} + (TIME_W+1)'(nomac_timeout);
    assign now_ext     = {1'b0, now_seconds};

    assign entry_valid = (main_limit >= now_ext) &&
                         (entry.mac_known || (nomac_limit >= now_ext));

endmodule
